FILE: rtl/yts_pkg.sv
package yts_pkg;

  // Which part of the timestamp the scanner is in.
  typedef enum logic [3:0] {
    PH_YEAR  = 4'd0,
    PH_MONTH = 4'd1,
    PH_DAY   = 4'd2,
    PH_BLANK = 4'd3,
    PH_HOUR  = 4'd4,
    PH_MIN   = 4'd5,
    PH_SEC   = 4'd6,
    PH_FRAC  = 4'd7,
    PH_ZH    = 4'd8,
    PH_ZM    = 4'd9,
    PH_ZEND  = 4'd10
  } phase_t;

  // Scanner state carried from one character to the next.
  typedef struct packed {
    phase_t     phase;
    logic [3:0] digit_count;
    logic [6:0] field_value;
    logic       letter_sep;
    logic       rejected;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:       PH_YEAR,
    digit_count: 4'd0,
    field_value: 7'd0,
    letter_sep:  1'b0,
    rejected:    1'b0
  };

endpackage

FILE: rtl/yts_channels.sv
// Character channel: one byte of the scalar and its end-of-scalar mark.
interface yts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// Result channel: one verdict per scalar.
interface yts_result_if;
  logic valid;
  logic ready;
  logic is_timestamp;

  modport source (output valid, output is_timestamp, input ready);
  modport sink   (input valid, input is_timestamp, output ready);
endinterface

FILE: rtl/yts_step.sv
module yts_step (
  input  yts_pkg::scan_state_t st,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  output yts_pkg::scan_state_t st_next,
  output logic                 is_match
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  function automatic logic field_ok(yts_pkg::scan_state_t s, logic [6:0] lo, logic [6:0] hi);
    return (s.digit_count >= 4'd1) && (s.digit_count <= 4'd2) &&
           (s.field_value >= lo) && (s.field_value <= hi);
  endfunction

  function automatic logic end_ok(yts_pkg::scan_state_t s);
    logic r;
    r = 1'b0;
    case (s.phase)
      yts_pkg::PH_DAY:  r = field_ok(s, 7'd1, 7'd31);
      yts_pkg::PH_SEC:  r = !s.letter_sep && field_ok(s, 7'd0, 7'd59);
      yts_pkg::PH_FRAC: r = !s.letter_sep && (s.digit_count >= 4'd1) &&
                            (s.digit_count <= 4'd9);
      yts_pkg::PH_ZM:   r = (s.digit_count == 4'd2);
      yts_pkg::PH_ZEND: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  logic                 is_digit;
  logic [3:0]           digit;
  logic                 is_blank;
  logic                 digit_field;
  logic [10:0]          acc;
  logic                 zone_ok;
  yts_pkg::phase_t      zone_phase;
  logic                 ok;
  yts_pkg::scan_state_t scanned;
  yts_pkg::scan_state_t after;

  assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit       = 4'(char_code - CH_ZERO);
  assign is_blank    = (char_code == CH_SPACE) || (char_code == CH_TAB);
  assign digit_field = (st.phase != yts_pkg::PH_BLANK) && (st.phase != yts_pkg::PH_ZEND) &&
                       (st.phase <= yts_pkg::PH_ZEND);
  assign acc         = {4'd0, st.field_value} * 11'd10 + {7'd0, digit};

  // A zone may only follow the time when the date was split by a letter.
  always_comb begin
    zone_ok    = 1'b0;
    zone_phase = yts_pkg::PH_ZEND;
    if (st.letter_sep) begin
      if (char_code == CH_Z_UP) begin
        zone_ok = 1'b1;
      end else if (char_code == CH_PLUS || char_code == CH_DASH) begin
        zone_ok    = 1'b1;
        zone_phase = yts_pkg::PH_ZH;
      end
    end
  end

  always_comb begin
    scanned = st;
    ok      = 1'b0;
    if (is_digit && digit_field) begin
      ok = 1'b1;
      if (st.digit_count < 4'd2) begin
        scanned.field_value = acc[6:0];
      end
      if (st.digit_count != 4'd15) begin
        scanned.digit_count = st.digit_count + 4'd1;
      end
    end else begin
      // Every accepted separator opens a fresh field.
      scanned.digit_count = 4'd0;
      scanned.field_value = 7'd0;
      case (st.phase)
        yts_pkg::PH_YEAR: begin
          if (char_code == CH_DASH && st.digit_count == 4'd4) begin
            ok            = 1'b1;
            scanned.phase = yts_pkg::PH_MONTH;
          end
        end
        yts_pkg::PH_MONTH: begin
          if (char_code == CH_DASH && field_ok(st, 7'd1, 7'd12)) begin
            ok            = 1'b1;
            scanned.phase = yts_pkg::PH_DAY;
          end
        end
        yts_pkg::PH_DAY: begin
          if (field_ok(st, 7'd1, 7'd31)) begin
            if (char_code == CH_T_UP || char_code == CH_T_LO) begin
              ok                 = 1'b1;
              scanned.letter_sep = 1'b1;
              scanned.phase      = yts_pkg::PH_HOUR;
            end else if (is_blank) begin
              ok            = 1'b1;
              scanned.phase = yts_pkg::PH_BLANK;
            end
          end
        end
        yts_pkg::PH_BLANK: begin
          if (is_blank) begin
            ok = 1'b1;
          end else if (is_digit) begin
            ok                  = 1'b1;
            scanned.phase       = yts_pkg::PH_HOUR;
            scanned.digit_count = 4'd1;
            scanned.field_value = {3'd0, digit};
          end
        end
        yts_pkg::PH_HOUR: begin
          if (char_code == CH_COLON && field_ok(st, 7'd0, 7'd23)) begin
            ok            = 1'b1;
            scanned.phase = yts_pkg::PH_MIN;
          end
        end
        yts_pkg::PH_MIN: begin
          if (char_code == CH_COLON && field_ok(st, 7'd0, 7'd59)) begin
            ok            = 1'b1;
            scanned.phase = yts_pkg::PH_SEC;
          end
        end
        yts_pkg::PH_SEC: begin
          if (field_ok(st, 7'd0, 7'd59)) begin
            if (char_code == CH_DOT) begin
              ok            = 1'b1;
              scanned.phase = yts_pkg::PH_FRAC;
            end else if (zone_ok) begin
              ok            = 1'b1;
              scanned.phase = zone_phase;
            end
          end
        end
        yts_pkg::PH_FRAC: begin
          if (st.digit_count >= 4'd1 && st.digit_count <= 4'd9 && zone_ok) begin
            ok            = 1'b1;
            scanned.phase = zone_phase;
          end
        end
        yts_pkg::PH_ZH: begin
          if (char_code == CH_COLON && st.digit_count == 4'd2) begin
            ok            = 1'b1;
            scanned.phase = yts_pkg::PH_ZM;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
    scanned.rejected = !ok;
  end

  // Once rejected, the scanner holds still until the end of the scalar.
  assign after    = st.rejected ? st : scanned;
  assign is_match = !after.rejected && end_ok(after);
  assign st_next  = last_char ? yts_pkg::SCAN_RESET : after;

endmodule

FILE: rtl/yaml_timestamp_recognizer.sv
// Channel   Role     Payload                    Item
// text      sink     char_code[7:0], last_char  one byte of the scalar
// verdict   source   is_timestamp               one per scalar, on its last byte
//
// One byte is taken every cycle unless a stalled verdict holds the input
// register. A byte waits in the input register while the scan step works on
// it; on the last byte the state and the result register are both loaded
// from the step, and the verdict leaves from the result register.
// Reset is synchronous and clears the scanner state and both valid flags.
// A stalled verdict holds the input register only when that register holds
// the last byte of the next scalar; all other bytes keep flowing.
module yaml_timestamp_recognizer (
  input logic                clk,
  input logic                rst,
  yts_char_if.sink           text,
  yts_result_if.source       verdict
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // Scanner state and its update.
  yts_pkg::scan_state_t st;
  yts_pkg::scan_state_t st_next;
  logic                 step_match;

  // Result register.
  logic out_valid;
  logic out_match;

  logic out_free;
  logic step_go;

  // A byte that closes a scalar can only move on when the result register
  // has room; every other byte moves on unconditionally.
  assign out_free   = !out_valid || verdict.ready;
  assign step_go    = in_valid && (!in_last || out_free);
  assign text.ready = !in_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_char <= text.char_code;
      in_last <= text.last_char;
    end
  end

  yts_step u_step (
    .st        (st),
    .char_code (in_char),
    .last_char (in_last),
    .st_next   (st_next),
    .is_match  (step_match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= yts_pkg::SCAN_RESET;
    end else if (step_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && in_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && in_last) begin
      out_match <= step_match;
    end
  end

  assign verdict.valid        = out_valid;
  assign verdict.is_timestamp = out_match;

endmodule

FILE: rtl/yts_checker.sv
module yts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit
);

  // Scalars whose last byte has been taken but whose verdict is not yet out.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready && in_last)
                         - 2'(out_valid && out_ready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bit))
    else $error("verdict changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("verdict without a finished scalar");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two scalars in flight");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict valid after reset");

endmodule

bind yaml_timestamp_recognizer yts_checker u_yts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .in_last   (text.last_char),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .out_bit   (verdict.is_timestamp)
);
